// ----- rtl/core/bpp_pkg.sv -----
// Shared types, constants and the fixed-point helper of the binomial put pricer.
package bpp_pkg;

   localparam int DIV_DVW  = 49;
   localparam int DIV_DSW  = 32;
   localparam int DIV_CNTW = 6;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_DOWN_LOW = 3'd1,
      STATUS_DOWN_HI  = 3'd2,
      STATUS_UP_LOW   = 3'd3,
      STATUS_QUERY    = 3'd4
   } status_type;

   localparam logic [2:0] REG_UP     = 3'd0;
   localparam logic [2:0] REG_DOWN   = 3'd1;
   localparam logic [2:0] REG_RATE   = 3'd2;
   localparam logic [2:0] REG_S0     = 3'd3;
   localparam logic [2:0] REG_STRIKE = 3'd4;
   localparam logic [2:0] REG_PERIOD = 3'd5;

   typedef struct packed {
      logic                 start;
      logic [DIV_DVW-1:0]   dividend;
      logic [DIV_DSW-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_DVW-1:0]   quotient;
   } div_rsp_type;

   // Price times a Q2.16 factor, rounded to nearest, saturated to 32 bits.
   function automatic logic [31:0] fx_scale(input logic [31:0] s, input logic [17:0] f);
      logic [49:0] prod;
      prod = ({18'd0, s} * {32'd0, f}) + 50'd32768;
      if (prod[49:48] != 2'd0) begin
         fx_scale = 32'hFFFF_FFFF;
      end else begin
         fx_scale = prod[47:16];
      end
   endfunction

endpackage

// ----- rtl/core/binomial_put_option_pricer.sv -----
// Top level of the binomial European put pricer: register file, sequencer and datapath.
//
// The block prices a European put on a recombining binomial lattice of n periods
// (period_count, clamped to 1..MAX_PERIODS). Each item names a node by its up and
// down move counts; the block returns the time-zero price, the delta hedge at that
// node and a status. It checks the arbitrage conditions first (down factor zero,
// down factor at or above 1+r, 1+r at or above the up factor) and then whether the
// node lies inside the lattice; on any of these the price and delta read zero and
// the item goes straight to its result. Otherwise the item runs through one
// division for the risk-neutral probability, the terminal payoffs (n+1 nodes, each
// priced by n multiplies), n(n+1)/2 backward-induction node updates and one
// division for delta from the spots of the node's two successors, made only when
// the up spot exceeds the down spot. Every node update and every division passes
// through one shared one-bit-per-cycle divider of 49 quotient bits. The lattice
// row lives in a memory with one write and one registered read port. One item is
// worked on at a time; a finished result waits in the output register while the
// next item is accepted. Configuration must be written through the APB-style port
// only while the block is idle; the block itself does not enforce this.
module binomial_put_option_pricer
   import bpp_pkg::*;
#(
   parameter int MAX_PERIODS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_up_moves,
   input  logic [5:0]  req_down_moves,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_option_value,
   output logic signed [17:0] rsp_hedge_delta,
   output logic [2:0]  rsp_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(MAX_PERIODS + 1);
   localparam int CW = (AW > 7) ? AW : 7;

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_CHECK = 14'b00000000000010,
      S_PDIV  = 14'b00000000000100,
      S_PRICE = 14'b00000000001000,
      S_TWR   = 14'b00000000010000,
      S_BSTEP = 14'b00000000100000,
      S_BLOAD = 14'b00000001000000,
      S_BMUL1 = 14'b00000010000000,
      S_BMUL2 = 14'b00000100000000,
      S_BDIV  = 14'b00001000000000,
      S_DSD   = 14'b00010000000000,
      S_DDIV  = 14'b00100000000000,
      S_DONE  = 14'b01000000000000,
      S_SPARE = 14'b10000000000000
   } state_type;

   typedef enum logic [1:0] {
      RET_TERM = 2'd0,
      RET_SU   = 2'd1,
      RET_SD   = 2'd2
   } ret_type;

   // Configuration registers.
   logic [17:0] up_ff, down_ff;
   logic [15:0] rate_ff;
   logic [31:0] s0_ff, strike_ff;
   logic [6:0]  period_ff;
   logic        csr_wr;

   // Sequencer and datapath registers.
   state_type   state_ff, state_in;
   ret_type     ret_ff, ret_in;
   logic [5:0]  h_ff, h_in, t_ff, t_in;
   logic [CW-1:0] n_ff, n_in, j_ff, j_in, step_ff, step_in, ups_ff, ups_in, dns_ff, dns_in;
   logic [31:0] s_ff, s_in, su_ff, su_in, a_ff, a_in, b_ff, b_in;
   logic [31:0] vu_ff, vu_in, vd_ff, vd_in;
   logic [16:0] p_ff, p_in, q_ff, q_in;
   logic [DIV_DVW-1:0] prod_ff, prod_in;
   logic [31:0] val_ff, val_in;
   logic [17:0] dlt_ff, dlt_in;
   logic [2:0]  sts_ff, sts_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [17:0] rsp_delta_ff, rsp_delta_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic        neg_ff, neg_in;

   // Combinational helpers.
   logic [17:0] onepr;
   logic [CW-1:0] n_clamp, lvl, hsum, t_ext, h_ext;
   logic [17:0] pdiff, udiff;
   logic [DIV_DVW-1:0] mul_bq;
   logic [31:0] v_sat, mag, den;
   logic [16:0] dq;

   logic          mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   logic [31:0]   mem_wr_data, mem_rd_data;

   div_req_type div_req;
   div_rsp_type div_rsp;

   bpp_row_mem #(.DEPTH(MAX_PERIODS + 1), .AW(AW)) u_row_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   bpp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   // The configuration port completes a write in its access phase.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff     <= 18'd78643;
         down_ff   <= 18'd52429;
         rate_ff   <= 16'd3277;
         s0_ff     <= 32'd262144;
         strike_ff <= 32'd327680;
         period_ff <= 7'd3;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_UP:     up_ff     <= csr_pwdata[17:0];
            REG_DOWN:   down_ff   <= csr_pwdata[17:0];
            REG_RATE:   rate_ff   <= csr_pwdata[15:0];
            REG_S0:     s0_ff     <= csr_pwdata;
            REG_STRIKE: strike_ff <= csr_pwdata;
            REG_PERIOD: period_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_UP:     csr_prdata = {14'd0, up_ff};
         REG_DOWN:   csr_prdata = {14'd0, down_ff};
         REG_RATE:   csr_prdata = {16'd0, rate_ff};
         REG_S0:     csr_prdata = s0_ff;
         REG_STRIKE: csr_prdata = strike_ff;
         REG_PERIOD: csr_prdata = {25'd0, period_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // Fixed quantities derived from the configuration and the latched query.
   assign onepr = {2'b01, rate_ff};
   assign pdiff = onepr - down_ff;
   assign udiff = up_ff - down_ff;
   assign h_ext = CW'(h_ff);
   assign t_ext = CW'(t_ff);
   assign hsum  = h_ext + t_ext;
   assign lvl   = hsum + CW'(1);

   always_comb begin
      if (period_ff == 7'd0) begin
         n_clamp = CW'(1);
      end else if (CW'(period_ff) > CW'(MAX_PERIODS)) begin
         n_clamp = CW'(MAX_PERIODS);
      end else begin
         n_clamp = CW'(period_ff);
      end
   end

   assign mul_bq = b_ff * q_ff;
   assign v_sat  = (div_rsp.quotient[DIV_DVW-1:32] != '0) ? 32'hFFFF_FFFF
                                                          : div_rsp.quotient[31:0];
   assign mag    = neg_ff ? (vd_ff - vu_ff) : (vu_ff - vd_ff);
   assign den    = su_ff - s_ff;
   assign dq     = (div_rsp.quotient > DIV_DVW'(65536)) ? 17'd65536
                                                        : div_rsp.quotient[16:0];

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      h_in          = h_ff;
      t_in          = t_ff;
      n_in          = n_ff;
      j_in          = j_ff;
      step_in       = step_ff;
      ups_in        = ups_ff;
      dns_in        = dns_ff;
      s_in          = s_ff;
      su_in         = su_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      vu_in         = vu_ff;
      vd_in         = vd_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      prod_in       = prod_ff;
      val_in        = val_ff;
      dlt_in        = dlt_ff;
      sts_in        = sts_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_delta_in  = rsp_delta_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = j_ff[AW-1:0];
      mem_wr_data   = 32'd0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               h_in     = req_up_moves;
               t_in     = req_down_moves;
               n_in     = n_clamp;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            val_in = 32'd0;
            dlt_in = 18'd0;
            if (down_ff == 18'd0) begin
               sts_in   = STATUS_DOWN_LOW;
               state_in = S_DONE;
            end else if (down_ff >= onepr) begin
               sts_in   = STATUS_DOWN_HI;
               state_in = S_DONE;
            end else if (onepr >= up_ff) begin
               sts_in   = STATUS_UP_LOW;
               state_in = S_DONE;
            end else if (hsum >= n_ff) begin
               sts_in   = STATUS_QUERY;
               state_in = S_DONE;
            end else begin
               sts_in           = STATUS_OK;
               div_req.start    = 1'b1;
               div_req.dividend = (DIV_DVW'(pdiff) << 16) + DIV_DVW'(udiff >> 1);
               div_req.divisor  = DIV_DSW'(udiff);
               state_in         = S_PDIV;
            end
         end
         S_PDIV: begin
            if (div_rsp.done) begin
               p_in     = div_rsp.quotient[16:0];
               q_in     = 17'd65536 - div_rsp.quotient[16:0];
               j_in     = '0;
               s_in     = s0_ff;
               ups_in   = n_ff;
               dns_in   = '0;
               ret_in   = RET_TERM;
               state_in = S_PRICE;
            end
         end
         S_PRICE: begin
            // Ups are applied before downs, each with its own rounding.
            if (ups_ff != '0) begin
               s_in   = fx_scale(s_ff, up_ff);
               ups_in = ups_ff - CW'(1);
            end else if (dns_ff != '0) begin
               s_in   = fx_scale(s_ff, down_ff);
               dns_in = dns_ff - CW'(1);
            end else begin
               unique case (ret_ff)
                  RET_TERM: state_in = S_TWR;
                  RET_SU: begin
                     su_in    = s_ff;
                     s_in     = s0_ff;
                     ups_in   = h_ext;
                     dns_in   = t_ext + CW'(1);
                     ret_in   = RET_SD;
                  end
                  RET_SD:  state_in = S_DSD;
                  default: state_in = S_DSD;
               endcase
            end
         end
         S_TWR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = (strike_ff > s_ff) ? (strike_ff - s_ff) : 32'd0;
            if (lvl == n_ff && j_ff == t_ext) begin
               vu_in = mem_wr_data;
            end
            if (lvl == n_ff && j_ff == t_ext + CW'(1)) begin
               vd_in = mem_wr_data;
            end
            if (j_ff == n_ff) begin
               step_in  = n_ff - CW'(1);
               state_in = S_BSTEP;
            end else begin
               j_in     = j_ff + CW'(1);
               s_in     = s0_ff;
               ups_in   = n_ff - j_ff - CW'(1);
               dns_in   = j_ff + CW'(1);
               state_in = S_PRICE;
            end
         end
         S_BSTEP: begin
            j_in        = '0;
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_in    = S_BLOAD;
         end
         S_BLOAD: begin
            a_in        = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(1);
            state_in    = S_BMUL1;
         end
         S_BMUL1: begin
            b_in     = mem_rd_data;
            prod_in  = a_ff * p_ff;
            state_in = S_BMUL2;
         end
         S_BMUL2: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff + mul_bq + DIV_DVW'(onepr >> 1);
            div_req.divisor  = DIV_DSW'(onepr);
            state_in         = S_BDIV;
         end
         S_BDIV: begin
            if (div_rsp.done) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = v_sat;
               if (lvl == step_ff && j_ff == t_ext) begin
                  vu_in = v_sat;
               end
               if (lvl == step_ff && j_ff == t_ext + CW'(1)) begin
                  vd_in = v_sat;
               end
               if (j_ff == step_ff) begin
                  if (step_ff == '0) begin
                     val_in   = v_sat;
                     s_in     = s0_ff;
                     ups_in   = h_ext + CW'(1);
                     dns_in   = t_ext;
                     ret_in   = RET_SU;
                     state_in = S_PRICE;
                  end else begin
                     step_in  = step_ff - CW'(1);
                     state_in = S_BSTEP;
                  end
               end else begin
                  // The old right neighbor becomes the left operand of the next node.
                  a_in        = b_ff;
                  j_in        = j_ff + CW'(1);
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = AW'(j_ff + CW'(2));
                  state_in    = S_BMUL1;
               end
            end
         end
         S_DSD: begin
            if (su_ff > s_ff) begin
               neg_in           = vu_ff < vd_ff;
               state_in         = S_DDIV;
            end else begin
               dlt_in   = 18'd0;
               state_in = S_DONE;
            end
         end
         S_DDIV: begin
            // Launch on entry, then wait for the quotient.
            if (!div_rsp.busy && !div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_DVW'({mag, 16'd0}) + DIV_DVW'(den >> 1);
               div_req.divisor  = den;
            end
            if (div_rsp.done) begin
               dlt_in   = neg_ff ? 18'(-{1'b0, dq}) : {1'b0, dq};
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_ff;
               rsp_delta_in  = dlt_ff;
               rsp_status_in = sts_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff        <= ret_in;
      h_ff          <= h_in;
      t_ff          <= t_in;
      n_ff          <= n_in;
      j_ff          <= j_in;
      step_ff       <= step_in;
      ups_ff        <= ups_in;
      dns_ff        <= dns_in;
      s_ff          <= s_in;
      su_ff         <= su_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      vu_ff         <= vu_in;
      vd_ff         <= vd_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      prod_ff       <= prod_in;
      val_ff        <= val_in;
      dlt_ff        <= dlt_in;
      sts_ff        <= sts_in;
      neg_ff        <= neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_delta_ff  <= rsp_delta_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_option_value = rsp_value_ff;
   assign rsp_hedge_delta  = rsp_delta_ff;
   assign rsp_status       = rsp_status_ff;

   // An error result carries neither a price nor a delta.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_option_value == 32'd0 &&
                                                rsp_hedge_delta == 18'sd0)
      else $error("error result with nonzero payload");

   // The row memory is never read and written at the same entry in one cycle.
   a_mem_rw: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
      else $error("row memory read and write collide");

   // The shared divider is only launched when it is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider launched while busy");

   // Delta stays within plus or minus one.
   a_delta_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hedge_delta <= 18'sd65536 && rsp_hedge_delta >= -18'sd65536)
      else $error("delta out of range");

endmodule

// ----- rtl/core/bpp_div.sv -----
// Restoring divider that retires one quotient bit per cycle.
module bpp_div
   import bpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIV_CNTW-1:0] cnt_ff, cnt_in;
   logic [DIV_DSW-1:0]  rem_ff, rem_in;
   logic [DIV_DVW-1:0]  quo_ff, quo_in;
   logic [DIV_DSW-1:0]  dsr_ff, dsr_in;
   logic [DIV_DSW:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DIV_DVW-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNTW'(DIV_DVW - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIV_DSW'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIV_DVW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DSW-1:0];
            quo_in = {quo_ff[DIV_DVW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNTW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- rtl/core/bpp_row_mem.sv -----
// One lattice time slice of put values, one write and one registered read port.
module bpp_row_mem
   import bpp_pkg::*;
#(
   parameter int DEPTH = 65,
   parameter int AW    = 7
)
(
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- dv/put_price_checker.sv -----
// Checker for the binomial put pricer: predicts every query and compares results.
`timescale 1ns / 100ps

module put_price_checker
   import bpp_pkg::*;
#(
   parameter int MAX_PERIODS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [5:0]  req_up_moves,
   input  logic [5:0]  req_down_moves,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_option_value,
   input  logic signed [17:0] rsp_hedge_delta,
   input  logic [2:0]  rsp_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          error_count,
   output int          pending_count,
   output int          checked_count
);

   typedef struct packed {
      logic [31:0]        price;
      logic signed [17:0] delta;
      status_type         status;
   } quote_type;

   logic [17:0] up_f, down_f;
   logic [15:0] rate;
   logic [31:0] spot, strike;
   logic [6:0]  periods;

   quote_type expected_quotes[$];

   function automatic longint unsigned lattice_spot(input int ups, input int downs);
      longint unsigned s;
      s = spot;
      for (int k = 0; k < ups; k++) begin
         s = (s * up_f + 32768) >> 16;
         if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
      end
      for (int k = 0; k < downs; k++) begin
         s = (s * down_f + 32768) >> 16;
         if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
      end
      return s;
   endfunction

   function automatic quote_type price_put(input logic [5:0] h, input logic [5:0] t);
      longint unsigned onepr, p, q, su, sd, den, mag, rq, v, s, vu, vd;
      longint          signed_delta;
      int              n, lvl;
      logic [31:0]     row [0:MAX_PERIODS];
      quote_type       res;
      onepr = 65536 + rate;
      n = periods;
      if (n < 1) n = 1;
      if (n > MAX_PERIODS) n = MAX_PERIODS;
      res = '0;
      vu = 0;
      vd = 0;
      if (down_f == 0) res.status = STATUS_DOWN_LOW;
      else if (down_f >= onepr) res.status = STATUS_DOWN_HI;
      else if (onepr >= up_f) res.status = STATUS_UP_LOW;
      else if (int'(h) + int'(t) >= n) res.status = STATUS_QUERY;
      else res.status = STATUS_OK;
      if (res.status != STATUS_OK) return res;

      p = ((onepr - down_f) * 65536 + (up_f - down_f) / 2) / (up_f - down_f);
      q = 65536 - p;
      lvl = h + t + 1;
      for (int j = 0; j <= n; j++) begin
         s = lattice_spot(n - j, j);
         row[j] = (strike > s) ? 32'(strike - s) : 32'd0;
      end
      if (lvl == n) begin
         vu = row[t];
         vd = row[t + 1];
      end
      // Backward induction, one time slice per pass.
      for (int stp = n - 1; stp >= 0; stp--) begin
         for (int j = 0; j <= stp; j++) begin
            v = (longint'(row[j]) * p + longint'(row[j + 1]) * q + onepr / 2) / onepr;
            row[j] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
         end
         if (lvl == stp) begin
            vu = row[t];
            vd = row[t + 1];
         end
      end
      su = lattice_spot(h + 1, t);
      sd = lattice_spot(h, t + 1);
      signed_delta = 0;
      if (su > sd) begin
         den = su - sd;
         mag = (vu < vd) ? vd - vu : vu - vd;
         rq = (mag * 65536 + den / 2) / den;
         if (rq > 65536) rq = 65536;
         signed_delta = (vu < vd) ? -longint'(rq) : longint'(rq);
      end
      res.price = row[0];
      res.delta = signed_delta[17:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
               checked_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      quote_type want;
      if (reset) begin
         up_f = 18'd78643;
         down_f = 18'd52429;
         rate = 16'd3277;
         spot = 32'd262144;
         strike = 32'd327680;
         periods = 7'd3;
         expected_quotes.delete();
         error_count = 0;
         checked_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_UP:     up_f = csr_pwdata[17:0];
               REG_DOWN:   down_f = csr_pwdata[17:0];
               REG_RATE:   rate = csr_pwdata[15:0];
               REG_S0:     spot = csr_pwdata;
               REG_STRIKE: strike = csr_pwdata;
               REG_PERIOD: periods = csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_quotes.push_back(price_put(req_up_moves, req_down_moves));
         if (rsp_valid && rsp_ready) begin
            if (expected_quotes.size() == 0) begin
               report_mismatch("unexpected item, status", rsp_status, 0);
            end else begin
               want = expected_quotes.pop_front();
               if (rsp_option_value !== want.price)
                  report_mismatch("option_value", rsp_option_value, want.price);
               if (rsp_hedge_delta !== want.delta)
                  report_mismatch("hedge_delta", rsp_hedge_delta, want.delta);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
            checked_count++;
         end
      end
      pending_count = expected_quotes.size();
   end

endmodule

// ----- dv/tb_binomial_put_option_pricer.sv -----
// Testbench top of the binomial put pricer: stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb_binomial_put_option_pricer;
   import bpp_pkg::*;

   // Generous ceiling: covers the two full 64-period items and the few hundred
   // small-lattice items, even under heavy idling.
   localparam int CYCLE_LIMIT = 4_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [5:0]  req_up_moves;
   logic [5:0]  req_down_moves;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_option_value;
   logic signed [17:0] rsp_hedge_delta;
   logic [2:0]  rsp_status;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int error_count;
   int pending_count;
   int checked_count;
   int sent_count;
   int send_idle_pct;
   int recv_stall_pct;
   int cycle_count;

   binomial_put_option_pricer u_top (.*);

   put_price_checker u_checker (.*);

   // Clock with a 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The receiver stalls at random; the percentage changes from phase to phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: a hung block ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results pending", cycle_count,
                  pending_count);
         $display("tb_binomial_put_option_pricer: done, errors");
         $finish;
      end
   end

   // Sends one query. Entered and left at a falling edge. Valid is dropped only
   // when the sender idles, so it never sees two assignments in one step.
   task automatic send_query(input logic [5:0] h, input logic [5:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_up_moves <= h;
      req_down_moves <= t;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      @(negedge clock);
   endtask

   // Stops sending and waits until every predicted result has come back, plus
   // a short settle so the block is surely idle before the registers change.
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // One APB write: a setup phase, then an access phase.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_lattice(input logic [17:0] u, input logic [17:0] d,
                              input logic [15:0] r, input logic [31:0] s0,
                              input logic [31:0] k, input logic [6:0] n);
      drain();
      csr_write(REG_UP, {14'd0, u});
      csr_write(REG_DOWN, {14'd0, d});
      csr_write(REG_RATE, {16'd0, r});
      csr_write(REG_S0, s0);
      csr_write(REG_STRIKE, k);
      csr_write(REG_PERIOD, {25'd0, n});
   endtask

   // A random model. Mostly arbitrage-free with a small lattice; now and then
   // one of the arbitrage violations so that the status priority is exercised.
   task automatic random_lattice;
      logic [15:0] r;
      logic [17:0] u, d;
      int onepr;
      r = 16'($urandom_range(65535));
      onepr = 65536 + r;
      d = 18'($urandom_range(onepr - 1, 1));
      u = 18'($urandom_range(18'h3FFFF, onepr + 1));
      case ($urandom_range(9))
         0: d = 18'd0;
         1: d = 18'($urandom_range(18'h3FFFF, onepr));
         2: u = 18'($urandom_range(onepr, 0));
         default: ;
      endcase
      set_lattice(u, d, r, $urandom, ($urandom_range(3) == 0) ? $urandom : $urandom >> 8,
                  7'($urandom_range(8)));
   endtask

   // Random query: mostly nodes inside a lattice of n periods, the rest raw.
   task automatic random_query(input int n);
      int h, t;
      if (n < 1) n = 1;
      if ($urandom_range(9) < 6) begin
         h = $urandom_range(n - 1);
         t = $urandom_range(n - 1 - h);
         send_query(6'(h), 6'(t));
      end else begin
         send_query(6'($urandom), 6'($urandom));
      end
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_up_moves = '0;
      req_down_moves = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      sent_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Reset model first: every node of the three-period lattice,
      // the first node outside it and the corner values of both fields.
      send_query(6'd0, 6'd0);
      send_query(6'd1, 6'd0);
      send_query(6'd0, 6'd1);
      send_query(6'd2, 6'd0);
      send_query(6'd1, 6'd1);
      send_query(6'd0, 6'd2);
      send_query(6'd1, 6'd2);
      send_query(6'd63, 6'd63);
      send_query(6'd63, 6'd0);

      // Each arbitrage violation alone, then two at once to check the priority.
      set_lattice(18'd78643, 18'd0, 16'd3277, 32'd262144, 32'd327680, 7'd3);
      send_query(6'd0, 6'd0);
      set_lattice(18'd78643, 18'h3FFFF, 16'd3277, 32'd262144, 32'd327680, 7'd3);
      send_query(6'd0, 6'd0);
      set_lattice(18'd65536, 18'd52429, 16'd0, 32'd262144, 32'd327680, 7'd3);
      send_query(6'd0, 6'd0);
      set_lattice(18'd0, 18'd0, 16'hFFFF, 32'd262144, 32'd327680, 7'd3);
      send_query(6'd63, 6'd63);

      // Period count zero runs as one period; the register beyond the last is
      // written and must change nothing.
      set_lattice(18'h3FFFF, 18'd1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0);
      csr_write(3'd6, 32'hFFFF_FFFF);
      send_query(6'd0, 6'd0);
      send_query(6'd0, 6'd1);

      // Huge spot against a zero strike: every payoff is zero and the up spot
      // saturates, which leaves a zero value spread for delta.
      set_lattice(18'h3FFFF, 18'd65535, 16'd1, 32'hFFFF_FFFF, 32'd0, 7'd2);
      send_query(6'd0, 6'd0);
      send_query(6'd1, 6'd0);

      // Period count above the maximum is clamped to the full 64-period lattice;
      // the first two items are by far the slowest of the run.
      set_lattice(18'd70000, 18'd60000, 16'd1000, 32'd262144, 32'd327680, 7'h7F);
      send_query(6'd0, 6'd0);
      send_query(6'd31, 6'd32);
      send_query(6'd32, 6'd32);

      // Random part in four idling phases, each with two random models.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         for (int half = 0; half < 2; half++) begin
            random_lattice();
            n = u_checker.periods;
            for (int i = 0; i < 31; i++) begin
               random_query(n);
               // Once, the sender holds off until everything has come back.
               if (phase == 1 && half == 0 && i == 15) begin
                  req_valid <= 1'b0;
                  @(negedge clock);
                  while (pending_count != 0) @(negedge clock);
               end
            end
         end
      end

      drain();
      $display("Covered %0d queries and %0d results over the reset model, each arbitrage",
               sent_count, checked_count);
      $display("violation, clamped period counts and eight random models under idling.");
      if (error_count == 0) begin
         $display("tb_binomial_put_option_pricer: done, clean");
      end else begin
         $display("tb_binomial_put_option_pricer: done, errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/bpp_pkg.sv
rtl/core/bpp_div.sv
rtl/core/bpp_row_mem.sv
rtl/core/binomial_put_option_pricer.sv
dv/put_price_checker.sv
dv/tb_binomial_put_option_pricer.sv
